// ----- rtl/mips_pkg.sv -----
// shared types, opcodes and constants for the mips32 execute block
// no dependencies
package mips_pkg;

	localparam int DMEM_WORDS = 4096;
	localparam int DMEM_AW = $clog2(DMEM_WORDS);
	localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
	localparam int QDEPTH = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM = 6'h01;
	localparam logic [5:0] OP_J = 6'h02;
	localparam logic [5:0] OP_JAL = 6'h03;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;
	localparam logic [5:0] OP_BLEZ = 6'h06;
	localparam logic [5:0] OP_BGTZ = 6'h07;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_XORI = 6'h0E;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_LB = 6'h20;
	localparam logic [5:0] OP_LH = 6'h21;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_LBU = 6'h24;
	localparam logic [5:0] OP_LHU = 6'h25;
	localparam logic [5:0] OP_SB = 6'h28;
	localparam logic [5:0] OP_SH = 6'h29;
	localparam logic [5:0] OP_SW = 6'h2B;

	// regimm branch selectors carried in the rt field
	localparam logic [4:0] RT_BLTZ = 5'h00;
	localparam logic [4:0] RT_BGEZ = 5'h01;
	localparam logic [4:0] RT_BLTZAL = 5'h10;
	localparam logic [4:0] RT_BGEZAL = 5'h11;

	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV = 6'h1A;
	localparam logic [5:0] FN_DIVU = 6'h1B;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	typedef struct packed {
		logic        action;
		logic [31:0] word;
		logic [31:0] preload_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [31:0] mem_address;
		logic [31:0] mem_value;
		logic [1:0]  status;
	} out_item_t;

	// instruction classes found by the front end
	typedef enum logic [2:0] {
		CL_PRELOAD,
		CL_SIMPLE,
		CL_MUL,
		CL_DIV,
		CL_LOAD,
		CL_STORE,
		CL_UNKNOWN
	} iclass_t;

	typedef struct packed {
		iclass_t     cls;
		logic [31:0] word;
		logic [31:0] preload_address;
	} dec_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_DIV,
		S_MEM,
		S_DONE
	} ex_state_t;

endpackage

// ----- rtl/mips32_instruction_execute.sv -----
// top level of the mips32 integer execute block
// depends on mips_pkg, mips_front, mips_back (and mips_muldiv below it)
//
// one transaction in, one transaction out. each input transaction either
// preloads a data memory word or executes the instruction word fetched at
// the pc that the previous result reported as next_pc. writing start_pc
// loads the pc; write it only while the block is idle. the front end takes
// a transaction into a two-entry queue while the back end works on an
// earlier one. in the back end most instructions go from S_READ to S_DONE,
// loads and stores through S_MEM; mult/multu/div/divu through S_MUL and
// S_DIV, waiting on the one-bit-per-step shift-add / restoring-divide unit
// (32 steps). reading unwritten data memory words returns undefined data.
module mips32_instruction_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mips_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mips_pkg::out_item_t out_data
);

	// front to back queue signals
	logic                q_valid, q_ready;
	mips_pkg::dec_item_t q_data;

	mips_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	// back end holds all architectural state
	mips_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/mips_front.sv -----
// front end: accepts transactions, classifies them and queues them
// depends on mips_pkg
module mips_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mips_pkg::in_item_t  in_data,
	output logic                q_valid,
	input  logic                q_ready,
	output mips_pkg::dec_item_t q_data
);

	mips_pkg::dec_item_t       queue_q [mips_pkg::QDEPTH];
	logic                      wr_ptr_q, rd_ptr_q;
	logic [1:0]                count_q;
	mips_pkg::iclass_t         cls;
	logic [5:0]                op, fn;
	logic [4:0]                rt;
	logic                      push, pop;

	assign op = in_data.word[31:26];
	assign fn = in_data.word[5:0];
	assign rt = in_data.word[20:16];

	always_comb begin
		cls = mips_pkg::CL_UNKNOWN;
		if (in_data.action) begin
			cls = mips_pkg::CL_PRELOAD;
		end else if (op == mips_pkg::OP_SPECIAL) begin
			if (fn == mips_pkg::FN_MULT || fn == mips_pkg::FN_MULTU)
				cls = mips_pkg::CL_MUL;
			else if (fn == mips_pkg::FN_DIV || fn == mips_pkg::FN_DIVU)
				cls = mips_pkg::CL_DIV;
			else if (fn inside {mips_pkg::FN_SLL, mips_pkg::FN_SRL, mips_pkg::FN_SRA,
					mips_pkg::FN_SLLV, mips_pkg::FN_SRLV, mips_pkg::FN_SRAV,
					mips_pkg::FN_JR, mips_pkg::FN_JALR, mips_pkg::FN_MFHI,
					mips_pkg::FN_MTHI, mips_pkg::FN_MFLO, mips_pkg::FN_MTLO,
					[mips_pkg::FN_ADD:mips_pkg::FN_NOR], mips_pkg::FN_SLT,
					mips_pkg::FN_SLTU})
				cls = mips_pkg::CL_SIMPLE;
		end else if (op == mips_pkg::OP_REGIMM) begin
			if (rt inside {mips_pkg::RT_BLTZ, mips_pkg::RT_BGEZ, mips_pkg::RT_BLTZAL,
					mips_pkg::RT_BGEZAL})
				cls = mips_pkg::CL_SIMPLE;
		end else if (op inside {[mips_pkg::OP_J:mips_pkg::OP_LUI]}) begin
			cls = mips_pkg::CL_SIMPLE;
		end else if (op inside {mips_pkg::OP_LB, mips_pkg::OP_LH, mips_pkg::OP_LW,
				mips_pkg::OP_LBU, mips_pkg::OP_LHU}) begin
			cls = mips_pkg::CL_LOAD;
		end else if (op inside {mips_pkg::OP_SB, mips_pkg::OP_SH, mips_pkg::OP_SW}) begin
			cls = mips_pkg::CL_STORE;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = queue_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{cls: cls, word: in_data.word,
				preload_address: in_data.preload_address};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/mips_muldiv.sv -----
// iterative 32-bit multiply and divide unit, one bit per cycle
// no dependencies
module mips_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic        is_signed,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] hi,
	output logic [31:0] lo
);

	logic        busy_q, div_q, neg_q_q, neg_r_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] opb_q;
	logic [31:0] ua, ub;
	logic [32:0] rem_sh, diff;
	logic [32:0] msum;

	assign ua = (is_signed && a[31]) ? 32'd0 - a : a;
	assign ub = (is_signed && b[31]) ? 32'd0 - b : b;

	// divide: shift remainder left, trial subtract
	assign rem_sh = {acc_q[63:31]};
	assign diff   = rem_sh - {1'b0, opb_q};
	// multiply: add multiplicand into upper half when low bit set
	assign msum   = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, opb_q} : 33'd0);

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {32'd0, ua};
			opb_q <= ub;
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[32]) acc_q <= {diff[31:0], acc_q[30:0], 1'b1};
				else acc_q <= {rem_sh[31:0], acc_q[30:0], 1'b0};
			end else begin
				acc_q <= {msum, acc_q[31:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			div_q   <= 1'b0;
			neg_q_q <= 1'b0;
			neg_r_q <= 1'b0;
			cnt_q   <= 6'd0;
		end else if (start) begin
			busy_q  <= 1'b1;
			div_q   <= is_div;
			neg_q_q <= is_signed && (a[31] ^ b[31]);
			neg_r_q <= is_signed && a[31];
			cnt_q   <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) busy_q <= 1'b0;
		end
	end

	assign done = !busy_q;

	always_comb begin
		if (div_q) begin
			lo = neg_q_q ? 32'd0 - acc_q[31:0] : acc_q[31:0];
			hi = neg_r_q ? 32'd0 - acc_q[63:32] : acc_q[63:32];
		end else begin
			{hi, lo} = neg_q_q ? 64'd0 - acc_q : acc_q;
		end
	end

endmodule

// ----- rtl/mips_back.sv -----
// back end: register file, hi/lo, data memory and the execute sequencer
// depends on mips_pkg and mips_muldiv
module mips_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_data,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  mips_pkg::dec_item_t  q_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mips_pkg::out_item_t  out_data
);

	mips_pkg::ex_state_t state_q, state_d;
	mips_pkg::dec_item_t cur_q;
	mips_pkg::out_item_t res_q, res_d;
	logic [31:0]         pc_q, hi_q, lo_q, a_q, b_q;
	logic [31:0]         regs_q [32];
	logic [31:0]         dmem [mips_pkg::DMEM_WORDS];
	logic [31:0]         rdata_q;
	logic [mips_pkg::DMEM_AW-1:0] maddr;
	logic                dm_we;
	logic [31:0]         dm_wdata;
	logic                md_start, md_done;
	logic [31:0]         md_hi, md_lo;
	logic [31:0]         w, simm, imm, ea, pc4, btarget, wv, npc, mv, lmask;
	logic [5:0]          op, fn;
	logic [4:0]          rt, rd, sh, wi, sa;
	logic                wr, mw, set_hi, set_lo;
	logic [31:0]         hi_v, lo_v;
	logic [1:0]          st;
	logic [4:0]          lane;

	assign w    = cur_q.word;
	assign op   = w[31:26];
	assign rt   = w[20:16];
	assign rd   = w[15:11];
	assign sh   = w[10:6];
	assign fn   = w[5:0];
	assign imm  = {16'd0, w[15:0]};
	assign simm = {{16{w[15]}}, w[15:0]};
	assign ea   = a_q + simm;
	assign pc4  = pc_q + 32'd4;
	assign btarget = pc4 + {simm[29:0], 2'b00};
	assign lane = {ea[1:0], 3'b000};
	assign sa   = a_q[4:0];
	assign maddr = (cur_q.cls == mips_pkg::CL_PRELOAD)
		? cur_q.preload_address[mips_pkg::DMEM_AW+1:2] : ea[mips_pkg::DMEM_AW+1:2];

	// full result, valid in S_MEM (memory ops), S_DIV (mult/div), else S_READ
	always_comb begin
		wr = 1'b0; wi = 5'd0; wv = 32'd0; mw = 1'b0; mv = 32'd0; st = mips_pkg::ST_OK;
		npc = pc4; set_hi = 1'b0; set_lo = 1'b0; hi_v = md_hi; lo_v = md_lo;
		lmask = 32'd0;
		case (cur_q.cls)
			mips_pkg::CL_PRELOAD: npc = pc_q;
			mips_pkg::CL_UNKNOWN: st = mips_pkg::ST_UNKNOWN;
			mips_pkg::CL_MUL: begin
				set_hi = 1'b1; set_lo = 1'b1;
			end
			mips_pkg::CL_DIV: begin
				if (b_q == 32'd0) st = mips_pkg::ST_DIVZERO;
				else begin
					set_hi = 1'b1; set_lo = 1'b1;
				end
			end
			mips_pkg::CL_LOAD: begin
				wr = 1'b1; wi = rt;
				case (op)
					mips_pkg::OP_LB: wv = {{24{rdata_q[lane+7]}}, rdata_q[lane +: 8]};
					mips_pkg::OP_LBU: wv = {24'd0, rdata_q[lane +: 8]};
					mips_pkg::OP_LH: wv = ea[1] ? {{16{rdata_q[31]}}, rdata_q[31:16]}
						: {{16{rdata_q[15]}}, rdata_q[15:0]};
					mips_pkg::OP_LHU: wv = ea[1] ? {16'd0, rdata_q[31:16]}
						: {16'd0, rdata_q[15:0]};
					default: wv = rdata_q;
				endcase
			end
			mips_pkg::CL_STORE: begin
				mw = 1'b1;
				case (op)
					mips_pkg::OP_SB: begin
						mv = {24'd0, b_q[7:0]} << lane;
						lmask = 32'hFF << lane;
					end
					mips_pkg::OP_SH: begin
						mv = ea[1] ? {b_q[15:0], 16'd0} : {16'd0, b_q[15:0]};
						lmask = ea[1] ? 32'hFFFF_0000 : 32'h0000_FFFF;
					end
					default: begin
						mv = b_q; lmask = 32'hFFFF_FFFF;
					end
				endcase
			end
			default: begin
				if (op == mips_pkg::OP_SPECIAL) begin
					wr = 1'b1; wi = rd;
					case (fn)
						mips_pkg::FN_SLL: wv = b_q << sh;
						mips_pkg::FN_SRL: wv = b_q >> sh;
						mips_pkg::FN_SRA: wv = $signed(b_q) >>> sh;
						mips_pkg::FN_SLLV: wv = b_q << sa;
						mips_pkg::FN_SRLV: wv = b_q >> sa;
						mips_pkg::FN_SRAV: wv = $signed(b_q) >>> sa;
						mips_pkg::FN_JR: begin wr = 1'b0; npc = a_q; end
						mips_pkg::FN_JALR: begin wv = pc4; npc = a_q; end
						mips_pkg::FN_MFHI: wv = hi_q;
						mips_pkg::FN_MTHI: begin wr = 1'b0; set_hi = 1'b1; hi_v = a_q; end
						mips_pkg::FN_MFLO: wv = lo_q;
						mips_pkg::FN_MTLO: begin wr = 1'b0; set_lo = 1'b1; lo_v = a_q; end
						mips_pkg::FN_ADD, mips_pkg::FN_ADDU: wv = a_q + b_q;
						mips_pkg::FN_SUB, mips_pkg::FN_SUBU: wv = a_q - b_q;
						mips_pkg::FN_AND: wv = a_q & b_q;
						mips_pkg::FN_OR: wv = a_q | b_q;
						mips_pkg::FN_XOR: wv = a_q ^ b_q;
						mips_pkg::FN_NOR: wv = ~(a_q | b_q);
						mips_pkg::FN_SLT: wv = {31'd0, $signed(a_q) < $signed(b_q)};
						mips_pkg::FN_SLTU: wv = {31'd0, a_q < b_q};
						default: wr = 1'b0;
					endcase
				end else begin
					case (op)
						mips_pkg::OP_J: npc = {pc4[31:28], w[25:0], 2'b00};
						mips_pkg::OP_JAL: begin
							npc = {pc4[31:28], w[25:0], 2'b00};
							wr = 1'b1; wi = 5'd31; wv = pc4;
						end
						mips_pkg::OP_REGIMM: begin
							if (a_q[31] ^ rt[0]) npc = btarget;
							if (rt[4]) begin
								wr = 1'b1; wi = 5'd31; wv = pc4;
							end
						end
						mips_pkg::OP_BEQ: if (a_q == b_q) npc = btarget;
						mips_pkg::OP_BNE: if (a_q != b_q) npc = btarget;
						mips_pkg::OP_BLEZ: if (a_q == 32'd0 || a_q[31]) npc = btarget;
						mips_pkg::OP_BGTZ: if (a_q != 32'd0 && !a_q[31]) npc = btarget;
						mips_pkg::OP_ADDI, mips_pkg::OP_ADDIU: begin
							wr = 1'b1; wi = rt; wv = a_q + simm;
						end
						mips_pkg::OP_SLTI: begin
							wr = 1'b1; wi = rt; wv = {31'd0, $signed(a_q) < $signed(simm)};
						end
						mips_pkg::OP_SLTIU: begin
							wr = 1'b1; wi = rt; wv = {31'd0, a_q < simm};
						end
						mips_pkg::OP_ANDI: begin wr = 1'b1; wi = rt; wv = a_q & imm; end
						mips_pkg::OP_ORI: begin wr = 1'b1; wi = rt; wv = a_q | imm; end
						mips_pkg::OP_XORI: begin wr = 1'b1; wi = rt; wv = a_q ^ imm; end
						mips_pkg::OP_LUI: begin wr = 1'b1; wi = rt; wv = {w[15:0], 16'd0}; end
						default: ;
					endcase
				end
			end
		endcase
		if (wi == 5'd0) begin
			wr = 1'b0; wv = 32'd0;
		end
		if (!wr) begin
			wi = 5'd0; wv = 32'd0;
		end
		res_d.next_pc     = npc;
		res_d.reg_write   = wr;
		res_d.reg_index   = wi;
		res_d.reg_value   = wv;
		res_d.mem_write   = mw;
		res_d.mem_address = (cur_q.cls == mips_pkg::CL_LOAD || cur_q.cls == mips_pkg::CL_STORE)
			? ea : 32'd0;
		res_d.mem_value   = mv;
		res_d.status      = st;
		dm_wdata = (rdata_q & ~lmask) | mv;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mips_pkg::S_IDLE: if (q_valid) state_d = mips_pkg::S_READ;
			mips_pkg::S_READ: begin
				if (cur_q.cls == mips_pkg::CL_MUL || cur_q.cls == mips_pkg::CL_DIV)
					state_d = mips_pkg::S_MUL;
				else if (cur_q.cls == mips_pkg::CL_LOAD || cur_q.cls == mips_pkg::CL_STORE)
					state_d = mips_pkg::S_MEM;
				else state_d = mips_pkg::S_DONE;
			end
			mips_pkg::S_MUL: state_d = mips_pkg::S_DIV;
			mips_pkg::S_DIV: if (md_done) state_d = mips_pkg::S_DONE;
			mips_pkg::S_MEM: state_d = mips_pkg::S_DONE;
			mips_pkg::S_DONE: if (out_ready) state_d = mips_pkg::S_IDLE;
			default: state_d = mips_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_ready   = (state_q == mips_pkg::S_IDLE);
		out_valid = (state_q == mips_pkg::S_DONE);
		md_start  = (state_q == mips_pkg::S_MUL);
		dm_we     = 1'b0;
		if (state_q == mips_pkg::S_READ && cur_q.cls == mips_pkg::CL_PRELOAD) dm_we = 1'b1;
		if (state_q == mips_pkg::S_MEM && cur_q.cls == mips_pkg::CL_STORE) dm_we = 1'b1;
	end

	assign out_data = res_q;

	mips_muldiv u_muldiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (md_start),
		.is_div    (cur_q.cls == mips_pkg::CL_DIV),
		.is_signed (!fn[0]),
		.a         (a_q),
		.b         (b_q),
		.done      (md_done),
		.hi        (md_hi),
		.lo        (md_lo)
	);

	always_ff @(posedge clk) begin
		if (dm_we)
			dmem[maddr] <= (cur_q.cls == mips_pkg::CL_PRELOAD) ? cur_q.word : dm_wdata;
		rdata_q <= dmem[maddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == mips_pkg::S_IDLE && q_valid) cur_q <= q_data;
		if (state_q == mips_pkg::S_IDLE) begin
			a_q <= regs_q[q_data.word[25:21]];
			b_q <= regs_q[q_data.word[20:16]];
		end
		if (state_q != mips_pkg::S_DONE && state_d == mips_pkg::S_DONE) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mips_pkg::S_IDLE;
			pc_q    <= mips_pkg::START_PC_RESET;
			hi_q    <= 32'd0;
			lo_q    <= 32'd0;
			for (int i = 0; i < 32; i++) regs_q[i] <= 32'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) pc_q <= cfg_data;
			if (state_q != mips_pkg::S_DONE && state_d == mips_pkg::S_DONE) begin
				if (!cfg_we) pc_q <= res_d.next_pc;
				if (set_hi) hi_q <= hi_v;
				if (set_lo) lo_q <= lo_v;
				if (res_d.reg_write) regs_q[res_d.reg_index] <= res_d.reg_value;
			end
		end
	end

endmodule

// ----- rtl/mips_checker.sv -----
// port-level checks for the mips32 execute block
// depends on mips_pkg; bound to mips32_instruction_execute
module mips_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input mips_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");

	a_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reg_write |-> out_data.reg_index != 5'd0)
		else $error("register zero reported written");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.reg_write && out_data.mem_write))
		else $error("register and memory write together");

endmodule

bind mips32_instruction_execute mips_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- test/mips32_instruction_execute_test.sv -----
// self-checking testbench for the mips32 integer execute block
// depends on mips_pkg and mips32_instruction_execute in the rtl folder
`timescale 1ns / 100ps

module mips32_instruction_execute_test;
	import mips_pkg::*;

	localparam logic [4:0] RT_BAD = 5'h02;
	localparam logic [5:0] OP_BAD = 6'h3F;
	localparam logic [5:0] FN_BAD = 6'h01;
	localparam int DRAIN_CYCLES = 40;   // quiet cycles before a start_pc write
	localparam int STALL_LIMIT = 5000;  // cycles without any transaction

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// percentage of cycles in which each side holds back
	int send_idle = 0;
	int recv_stall = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	// transactions waiting to be sent, with their predicted results alongside
	in_item_t instr_pending[$];
	out_item_t results_pending[$];
	// results predicted for accepted transactions, oldest first
	out_item_t results_due[$];

	// architectural state mirror
	logic [31:0] gpr[32];
	logic [31:0] pc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] dmem[DMEM_WORDS];
	bit word_known[DMEM_WORDS];
	int known_words[$];

	mips32_instruction_execute i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	// instruction encoders
	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sh);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// executes one transaction on the mirror state and returns its result
	function automatic out_item_t execute_instr(in_item_t it);
		out_item_t r;
		logic [31:0] w, a, b, simm, ea, npc, wv, ua, ub, q, rm;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sh, wi;
		logic [15:0] imm;
		logic [63:0] prod;
		int lane, hlane, idx;
		bit wr;
		r = '0;
		w = it.word;
		npc = pc_q + 32'd4;
		wr = 0;
		wi = '0;
		wv = '0;
		if (it.action) begin
			idx = (it.preload_address >> 2) % DMEM_WORDS;
			dmem[idx] = w;
			word_known[idx] = 1;
			known_words.push_back(idx);
			npc = pc_q;
		end else begin
			op = w[31:26];
			rs = w[25:21];
			rt = w[20:16];
			rd = w[15:11];
			sh = w[10:6];
			fn = w[5:0];
			imm = w[15:0];
			simm = sext16(imm);
			a = gpr[rs];
			b = gpr[rt];
			ea = a + simm;
			lane = ea[1:0] * 8;
			hlane = ea[1] * 16;
			idx = (ea >> 2) % DMEM_WORDS;
			if (op == OP_SPECIAL) begin
				wi = rd;
				wr = 1;
				case (fn)
					FN_SLL: wv = b << sh;
					FN_SRL: wv = b >> sh;
					FN_SRA: wv = $signed(b) >>> sh;
					FN_SLLV: wv = b << a[4:0];
					FN_SRLV: wv = b >> a[4:0];
					FN_SRAV: wv = $signed(b) >>> a[4:0];
					FN_JR: begin
						wr = 0;
						npc = a;
					end
					FN_JALR: begin
						wv = pc_q + 32'd4;
						npc = a;
					end
					FN_MFHI: wv = hi_q;
					FN_MTHI: begin
						wr = 0;
						hi_q = a;
					end
					FN_MFLO: wv = lo_q;
					FN_MTLO: begin
						wr = 0;
						lo_q = a;
					end
					FN_MULT, FN_MULTU: begin
						wr = 0;
						if (fn == FN_MULT)
							prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						else
							prod = {32'd0, a} * {32'd0, b};
						hi_q = prod[63:32];
						lo_q = prod[31:0];
					end
					FN_DIV, FN_DIVU: begin
						wr = 0;
						if (b == 0) begin
							r.status = ST_DIVZERO;
						end else if (fn == FN_DIVU) begin
							lo_q = a / b;
							hi_q = a % b;
						end else begin
							// magnitudes, then signs: quotient by both, remainder by dividend
							ua = a[31] ? -a : a;
							ub = b[31] ? -b : b;
							q = ua / ub;
							rm = ua % ub;
							if (a[31] ^ b[31]) q = -q;
							if (a[31]) rm = -rm;
							lo_q = q;
							hi_q = rm;
						end
					end
					FN_ADD, FN_ADDU: wv = a + b;
					FN_SUB, FN_SUBU: wv = a - b;
					FN_AND: wv = a & b;
					FN_OR: wv = a | b;
					FN_XOR: wv = a ^ b;
					FN_NOR: wv = ~(a | b);
					FN_SLT: wv = {31'd0, $signed(a) < $signed(b)};
					FN_SLTU: wv = {31'd0, a < b};
					default: begin
						wr = 0;
						r.status = ST_UNKNOWN;
					end
				endcase
			end else if (op == OP_J || op == OP_JAL) begin
				npc = {npc[31:28], w[25:0], 2'b00};
				if (op == OP_JAL) begin
					wr = 1;
					wi = 5'd31;
					wv = pc_q + 32'd4;
				end
			end else begin
				wi = rt;
				case (op)
					OP_REGIMM: begin
						if (rt == RT_BLTZ || rt == RT_BLTZAL || rt == RT_BGEZ || rt == RT_BGEZAL) begin
							// bit 0 of rt picks "greater or equal", bit 4 picks link
							if (a[31] != rt[0]) npc = pc_q + 32'd4 + (simm << 2);
							if (rt[4]) begin
								wr = 1;
								wi = 5'd31;
								wv = pc_q + 32'd4;
							end
						end else begin
							r.status = ST_UNKNOWN;
						end
					end
					OP_BEQ: if (a == b) npc = npc + (simm << 2);
					OP_BNE: if (a != b) npc = npc + (simm << 2);
					OP_BLEZ: if (a == 0 || a[31]) npc = npc + (simm << 2);
					OP_BGTZ: if (a != 0 && !a[31]) npc = npc + (simm << 2);
					OP_ADDI, OP_ADDIU: begin
						wr = 1;
						wv = a + simm;
					end
					OP_SLTI: begin
						wr = 1;
						wv = {31'd0, $signed(a) < $signed(simm)};
					end
					OP_SLTIU: begin
						wr = 1;
						wv = {31'd0, a < simm};
					end
					OP_ANDI: begin
						wr = 1;
						wv = a & {16'd0, imm};
					end
					OP_ORI: begin
						wr = 1;
						wv = a | {16'd0, imm};
					end
					OP_XORI: begin
						wr = 1;
						wv = a ^ {16'd0, imm};
					end
					OP_LUI: begin
						wr = 1;
						wv = {imm, 16'd0};
					end
					OP_LB, OP_LBU: begin
						wr = 1;
						r.mem_address = ea;
						wv = (dmem[idx] >> lane) & 32'hFF;
						if (op == OP_LB) wv = {{24{wv[7]}}, wv[7:0]};
					end
					OP_LH, OP_LHU: begin
						wr = 1;
						r.mem_address = ea;
						wv = (dmem[idx] >> hlane) & 32'hFFFF;
						if (op == OP_LH) wv = sext16(wv[15:0]);
					end
					OP_LW: begin
						wr = 1;
						r.mem_address = ea;
						wv = dmem[idx];
					end
					OP_SB: begin
						r.mem_write = 1'b1;
						r.mem_address = ea;
						r.mem_value = (b & 32'hFF) << lane;
						dmem[idx] = (dmem[idx] & ~(32'hFF << lane)) | r.mem_value;
					end
					OP_SH: begin
						r.mem_write = 1'b1;
						r.mem_address = ea;
						r.mem_value = (b & 32'hFFFF) << hlane;
						dmem[idx] = (dmem[idx] & ~(32'hFFFF << hlane)) | r.mem_value;
					end
					OP_SW: begin
						r.mem_write = 1'b1;
						r.mem_address = ea;
						r.mem_value = b;
						dmem[idx] = b;
						if (!word_known[idx]) begin
							word_known[idx] = 1;
							known_words.push_back(idx);
						end
					end
					default: r.status = ST_UNKNOWN;
				endcase
			end
			pc_q = npc;
		end
		// register zero swallows writes
		if (wr && wi != 0) begin
			gpr[wi] = wv;
			r.reg_write = 1'b1;
			r.reg_index = wi;
			r.reg_value = wv;
		end
		r.next_pc = npc;
		return r;
	endfunction

	task automatic send_item(logic action, logic [31:0] word, logic [31:0] addr);
		in_item_t it;
		it.action = action;
		it.word = word;
		it.preload_address = addr;
		instr_pending.push_back(it);
		results_pending.push_back(execute_instr(it));
	endtask

	// loads are aimed at words that hold known data; the top imm bits stay random
	function automatic logic [31:0] aim_load(logic [31:0] w);
		logic [13:0] target;
		if (!(w[31:26] inside {OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW})) return w;
		target = {known_words[$urandom_range(0, known_words.size() - 1)][11:0],
			2'($urandom_range(0, 3))};
		w[13:0] = target - gpr[w[25:21]][13:0];
		return w;
	endfunction

	function automatic logic [31:0] random_instr();
		logic [5:0] fn_list[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
			FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
			FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
		logic [5:0] imm_list[] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
			OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
		logic [5:0] mem_list[] = '{OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW};
		logic [4:0] rt_list[] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};
		logic [31:0] w;
		int pick;
		w = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			w[31:26] = OP_SPECIAL;
			w[5:0] = fn_list[$urandom_range(0, fn_list.size() - 1)];
		end else if (pick < 65) begin
			w[31:26] = imm_list[$urandom_range(0, imm_list.size() - 1)];
		end else if (pick < 85) begin
			w[31:26] = mem_list[$urandom_range(0, mem_list.size() - 1)];
		end else if (pick < 90) begin
			w[31:26] = $urandom_range(0, 1) ? OP_J : OP_JAL;
		end else if (pick < 94) begin
			w[31:26] = OP_REGIMM;
			w[20:16] = rt_list[$urandom_range(0, 3)];
		end
		// anything else stays a raw random word, unknown codes included
		return aim_load(w);
	endfunction

	task automatic run_random(int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 12)
				send_item(1'b1, $urandom, $urandom);
			else
				send_item(1'b0, random_instr(), $urandom);
		end
	endtask

	task automatic wait_idle();
		while (instr_pending.size() != 0 || results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_pc(logic [31:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pc_q = value;
		@(posedge clk);
	endtask

	// driver: presents the head of the pending queue, holds it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				void'(instr_pending.pop_front());
				results_due.push_back(results_pending.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (instr_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data <= instr_pending[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back pressure, field by field check, watchdog
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(0, 99) >= recv_stall;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with nothing outstanding");
					error_count++;
				end else begin
					exp_item = results_due.pop_front();
					if (out_data.next_pc !== exp_item.next_pc) begin
						$error("next_pc expected %h got %h", exp_item.next_pc, out_data.next_pc);
						error_count++;
					end
					if (out_data.reg_write !== exp_item.reg_write) begin
						$error("reg_write expected %b got %b", exp_item.reg_write, out_data.reg_write);
						error_count++;
					end
					if (out_data.reg_index !== exp_item.reg_index) begin
						$error("reg_index expected %0d got %0d", exp_item.reg_index, out_data.reg_index);
						error_count++;
					end
					if (out_data.reg_value !== exp_item.reg_value) begin
						$error("reg_value expected %h got %h", exp_item.reg_value, out_data.reg_value);
						error_count++;
					end
					if (out_data.mem_write !== exp_item.mem_write) begin
						$error("mem_write expected %b got %b", exp_item.mem_write, out_data.mem_write);
						error_count++;
					end
					if (out_data.mem_address !== exp_item.mem_address) begin
						$error("mem_address expected %h got %h", exp_item.mem_address,
							out_data.mem_address);
						error_count++;
					end
					if (out_data.mem_value !== exp_item.mem_value) begin
						$error("mem_value expected %h got %h", exp_item.mem_value, out_data.mem_value);
						error_count++;
					end
					if (out_data.status !== exp_item.status) begin
						$error("status expected %0d got %0d", exp_item.status, out_data.status);
						error_count++;
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] pc_values[5];
		foreach (gpr[i]) gpr[i] = '0;
		pc_q = START_PC_RESET;
		hi_q = '0;
		lo_q = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, overflow, divide corners, lanes, jumps, unknown codes
		write_start_pc(32'h0000_0000);
		send_item(1'b1, 32'h80FF_7F01, 32'h0000_0100);
		send_item(1'b1, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
		send_item(1'b0, enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000), '0);
		send_item(1'b0, enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF), '0);
		send_item(1'b0, enc_i(OP_ADDI, 5'd1, 5'd3, 16'hFFFF), '0);
		send_item(1'b0, enc_r(FN_ADD, 5'd3, 5'd3, 5'd4, 5'd0), '0);
		send_item(1'b0, enc_r(FN_SUB, 5'd1, 5'd3, 5'd5, 5'd0), '0);
		send_item(1'b0, enc_r(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MFLO, 5'd0, 5'd0, 5'd7, 5'd0), '0);
		send_item(1'b0, enc_r(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MTHI, 5'd2, 5'd0, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_r(FN_MTLO, 5'd1, 5'd0, 5'd0, 5'd0), '0);
		send_item(1'b0, enc_i(OP_SLTIU, 5'd0, 5'd8, 16'hFFFF), '0);
		send_item(1'b0, enc_i(OP_ORI, 5'd0, 5'd9, 16'hFFFF), '0);
		send_item(1'b0, enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h0005), '0);
		send_item(1'b0, enc_r(FN_SRA, 5'd0, 5'd1, 5'd11, 5'd31), '0);
		send_item(1'b0, enc_i(OP_LB, 5'd0, 5'd12, 16'h0101), '0);
		send_item(1'b0, enc_i(OP_LH, 5'd0, 5'd13, 16'h0102), '0);
		send_item(1'b0, enc_i(OP_LW, 5'd0, 5'd14, 16'hFFFF), '0);
		send_item(1'b0, enc_i(OP_SB, 5'd0, 5'd2, 16'h0103), '0);
		send_item(1'b0, enc_i(OP_SH, 5'd0, 5'd1, 16'h0102), '0);
		send_item(1'b0, enc_i(OP_SW, 5'd0, 5'd2, 16'h0100), '0);
		send_item(1'b0, {OP_J, 26'h3FF_FFFF}, '0);
		send_item(1'b0, enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF), '0);
		send_item(1'b0, enc_i(OP_REGIMM, 5'd1, RT_BLTZAL, 16'h0002), '0);
		send_item(1'b0, enc_r(FN_JALR, 5'd2, 5'd0, 5'd15, 5'd0), '0);
		send_item(1'b0, {OP_BAD, 26'h0}, '0);
		send_item(1'b0, enc_r(FN_BAD, 5'd1, 5'd2, 5'd3, 5'd0), '0);
		send_item(1'b0, enc_i(OP_REGIMM, 5'd1, RT_BAD, 16'h0004), '0);

		// random phases, each under its own start pc; the idling mix cycles through four settings
		pc_values = '{32'hFFFF_FFFF, 32'hFFFF_FFFC, $urandom, START_PC_RESET, 32'h0000_0000};
		for (int ph = 0; ph < 5; ph++) begin
			write_start_pc(pc_values[ph]);
			case (ph % 4)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 56;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 56;
				end
				default: begin
					send_idle = 12;
					recv_stall = 12;
				end
			endcase
			run_random(295);
		end

		wait_idle();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mips_pkg.sv
rtl/mips_front.sv
rtl/mips_muldiv.sv
rtl/mips_back.sv
rtl/mips32_instruction_execute.sv
rtl/mips_checker.sv
test/mips32_instruction_execute_test.sv
